@@ hdl/collision_and_blind_spot_warning_top_defines.svh @@
// Assertion macros used by the checker file cbsw_checker.sv.
// No dependencies; include by bare file name.
`ifndef COLLISION_AND_BLIND_SPOT_WARNING_TOP_DEFINES_SVH
`define COLLISION_AND_BLIND_SPOT_WARNING_TOP_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define CBSW_ASSERT_IMP(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("cbsw assertion failed");

// Condition implies consequence in the next cycle.
`define CBSW_ASSERT_NXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("cbsw assertion failed");

`endif

@@ hdl/cbsw_pkg.sv @@
// Shared constants, types and the side-sensor update for the warning block.
// No dependencies.
package cbsw_pkg;

  localparam int SQRT_ITERATIONS = 10;
  localparam int ITER_W          = $clog2(SQRT_ITERATIONS);

  localparam int DIVIDEND_W = 49;
  localparam int DIVISOR_W  = 32;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_FCW_HIGH_DIST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FCW_MEDIUM_DIST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TTC_HIGH        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TTC_MEDIUM      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BSD_RANGE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BSD_DELTA       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BSD_TIMEOUT     = 3'd6;

  localparam logic [1:0] FCW_NONE   = 2'd0;
  localparam logic [1:0] FCW_MEDIUM = 2'd1;
  localparam logic [1:0] FCW_HIGH   = 2'd2;

  localparam logic [15:0] DIST_NONE = 16'hFFFF;

  // Q15.16 constants
  localparam logic signed [31:0] Q_MIN_CLOSING = 32'sd3277;
  localparam logic signed [31:0] Q_MIN_ACCEL   = 32'sd655;
  localparam logic [31:0]        Q_TTC_INVALID = 32'd65470464;  // 999.0
  localparam logic [17:0]        Q_DEADBAND    = 18'd9830;
  localparam logic [17:0]        Q_SPEED_LIMIT = 18'd183501;
  localparam logic [31:0]        Q_RESPONSE    = 32'd13107;
  localparam logic [31:0]        Q_SAFETY      = 32'd13107;
  localparam logic [31:0]        Q_WARN_MARGIN = 32'd26214;
  localparam logic [31:0]        Q_MAX         = 32'h7FFF_FFFF;
  localparam logic [31:0]        Q_ONE         = 32'd65536;
  // ceil(2^38 / 100): exact floor(n / 100) for any n below 2^32 after >> 38
  localparam logic [31:0]        RECIP_CM_PER_M = 32'd2748779070;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [15:0] last;
    logic [15:0] count;
    logic        warn;
  } side_t;

  function automatic side_t side_update(input logic [15:0] d, input logic [15:0] last,
                                        input logic [15:0] count, input logic [15:0] range,
                                        input logic [15:0] delta, input logic [15:0] timeout);
    side_t       r;
    logic [15:0] diff;
    diff = (d >= last) ? (d - last) : (last - d);
    r.last  = last;
    r.count = count;
    r.warn  = 1'b0;
    if (d == 16'd0 || d == DIST_NONE || d > range) begin
      r.last  = DIST_NONE;
      r.count = 16'd0;
    end else if (last == DIST_NONE || diff > delta) begin
      r.last  = d;
      r.count = 16'd0;
      r.warn  = 1'b1;
    end else if (count < timeout) begin
      r.count = count + 16'd1;
      r.warn  = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ hdl/cbsw_if.sv @@
// Valid/ready channel interfaces for input items and results.
// No dependencies.
interface cbsw_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] front_dist_cm;
  logic [31:0] closing_speed;
  logic [31:0] closing_accel;
  logic [31:0] own_speed;
  logic [15:0] left_dist_cm;
  logic [15:0] right_dist_cm;

  modport source (output valid, front_dist_cm, closing_speed, closing_accel, own_speed,
                  left_dist_cm, right_dist_cm, input ready);
  modport sink (input valid, front_dist_cm, closing_speed, closing_accel, own_speed,
                left_dist_cm, right_dist_cm, output ready);
endinterface

interface cbsw_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] fcw_level;
  logic       bsd_left;
  logic       bsd_right;

  modport source (output valid, fcw_level, bsd_left, bsd_right, input ready);
  modport sink (input valid, fcw_level, bsd_left, bsd_right, output ready);
endinterface

@@ hdl/collision_and_blind_spot_warning_top.sv @@
// Top level of the forward collision and blind spot warning block.
// Depends on cbsw_pkg, cbsw_if and cbsw_div.
//
// One transfer on in_ch produces exactly one transfer on out_ch. The block
// takes one item at a time: in_ch.ready is high only while the sequencer is
// idle. A single shared multiplier works out the brake distance, the front
// distance in metres (a multiplication by the reciprocal of 100) and the
// quadratic discriminant, and a single restoring divider does every other
// division in turn: the Newton square-root steps and the final time to
// collision. An item whose closing speed is too low does not use the
// divider, one whose acceleration is near zero uses it once, and one on
// the quadratic path uses it at most SQRT_ITERATIONS + 1 times; in_ch.ready
// rises again once the result is loaded into the output register.
// The result sits in an output register, so a new item is taken while a
// finished result still waits on out_ch; that item then holds in its last
// step for as long as out_ch stalls. Configuration writes through
// cfg_we/cfg_index/cfg_data take effect at once and must only happen while
// the block is idle; an index beyond the register list is ignored. Side
// sensors keep their last distance and a stationary tick count, updated once
// per item.
module collision_and_blind_spot_warning_top (
  input  logic                           clk,
  input  logic                           rst,
  cbsw_in_if.sink                        in_ch,
  cbsw_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [cbsw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbsw_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_BRK_LIN, S_BRK_SQ, S_BRK_SUM, S_DIST, S_SEL,
    S_VV, S_AD, S_WIDE, S_ROOT_GO, S_ROOT_WAIT, S_TIME_GO, S_TIME_WAIT, S_LEVEL
  } state_t;

  state_t state;

  // configuration
  logic [15:0] fcw_high_dist_cm, fcw_medium_dist_cm;
  logic [30:0] ttc_high_q16, ttc_medium_q16;
  logic [15:0] bsd_range_cm, side_still_cm, bsd_timeout_ticks;

  // side state
  logic [15:0] left_last_dist, right_last_dist;
  logic [15:0] left_stable_count, right_stable_count;

  // captured item
  logic [15:0]        front;
  logic signed [31:0] v, a;
  logic [17:0]        s;
  logic [15:0]        left_d, right_d;

  // working registers
  logic signed [65:0] prod;
  logic [16:0]        brake_lin;
  logic [31:0]        brake;
  logic [25:0]        d;
  logic signed [63:0] vv;
  logic [30:0]        x;
  logic [31:0]        g;
  logic [31:0]        root;
  logic [31:0]        ttc;
  logic               near_path;
  logic [cbsw_pkg::ITER_W-1:0] iter;

  // output register
  logic       out_valid;
  logic [1:0] out_level;
  logic       out_left, out_right;

  logic signed [32:0] mul_a, mul_b;
  cbsw_pkg::div_req_t div_req;
  cbsw_pkg::div_rsp_t div_rsp;

  logic signed [63:0] wide;
  logic [31:0]        gdiv;
  logic [32:0]        gsum;
  logic signed [33:0] num;
  logic [33:0]        num_neg;
  logic [32:0]        num_mag;
  logic [32:0]        a_neg;
  logic [31:0]        a_mag;
  logic               t_pos;
  logic signed [31:0] own;
  logic [1:0]         level;
  logic               near_accel;
  cbsw_pkg::side_t    left_res, right_res;

  assign in_ch.ready      = (state == S_IDLE);
  assign out_ch.valid     = out_valid;
  assign out_ch.fcw_level = out_level;
  assign out_ch.bsd_left  = out_left;
  assign out_ch.bsd_right = out_right;

  cbsw_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_BRK_LIN: begin
        mul_a = 33'(s);
        mul_b = 33'(cbsw_pkg::Q_RESPONSE);
      end
      S_BRK_SQ: begin
        mul_a = 33'(s);
        mul_b = 33'(s);
      end
      S_BRK_SUM: begin
        // centimetres to Q15.16 metres: (front * 65536) / 100
        mul_a = {1'b0, front, 16'd0};
        mul_b = 33'(cbsw_pkg::RECIP_CM_PER_M);
      end
      S_VV: begin
        mul_a = {v[31], v};
        mul_b = {v[31], v};
      end
      S_AD: begin
        mul_a = {a[31], a};
        mul_b = 33'(d);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign wide  = vv + {prod[62:0], 1'b0};
  assign gdiv  = (g == 32'd0) ? 32'd1 : g;
  assign gsum  = {1'b0, gdiv} + {1'b0, div_rsp.quotient[31:0]};
  assign num   = $signed({2'b00, root}) - 34'(v);
  assign num_neg = -num;
  assign num_mag = num[33] ? num_neg[32:0] : num[32:0];
  assign a_neg = -{a[31], a};
  assign a_mag = a[31] ? a_neg[31:0] : a;
  assign t_pos = (num > 34'sd0 && !a[31]) || (num < 34'sd0 && a[31]);
  assign own   = $signed(in_ch.own_speed);
  assign near_accel = (a > -cbsw_pkg::Q_MIN_ACCEL) && (a < cbsw_pkg::Q_MIN_ACCEL);

  // Divider launch: dividend and divisor depend on which division is due.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state)
      S_ROOT_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {2'b00, x, 16'd0};
        div_req.divisor  = gdiv;
      end
      S_TIME_GO: begin
        div_req.start = 1'b1;
        if (near_path) begin
          div_req.dividend = {7'd0, d, 16'd0};
          div_req.divisor  = v;
        end else begin
          div_req.dividend = {num_mag, 16'd0};
          div_req.divisor  = a_mag;
        end
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // Warning level and side updates from the finished figures.
  always_comb begin
    level = cbsw_pkg::FCW_NONE;
    if (front != 16'd0 && front != cbsw_pkg::DIST_NONE) begin
      if (front <= fcw_high_dist_cm || ttc <= {1'b0, ttc_high_q16} ||
          {6'd0, d} <= brake) begin
        level = cbsw_pkg::FCW_HIGH;
      end else if (front <= fcw_medium_dist_cm || ttc <= {1'b0, ttc_medium_q16} ||
                   {6'd0, d} <= brake + cbsw_pkg::Q_WARN_MARGIN) begin
        level = cbsw_pkg::FCW_MEDIUM;
      end
    end
    left_res  = cbsw_pkg::side_update(left_d, left_last_dist, left_stable_count,
                                      bsd_range_cm, side_still_cm, bsd_timeout_ticks);
    right_res = cbsw_pkg::side_update(right_d, right_last_dist, right_stable_count,
                                      bsd_range_cm, side_still_cm, bsd_timeout_ticks);
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state              <= S_IDLE;
      out_valid          <= 1'b0;
      fcw_high_dist_cm   <= 16'd35;
      fcw_medium_dist_cm <= 16'd100;
      ttc_high_q16       <= 31'd98304;
      ttc_medium_q16     <= 31'd196608;
      bsd_range_cm       <= 16'd40;
      side_still_cm      <= 16'd5;
      bsd_timeout_ticks  <= 16'd500;
      left_last_dist     <= cbsw_pkg::DIST_NONE;
      right_last_dist    <= cbsw_pkg::DIST_NONE;
      left_stable_count  <= 16'd0;
      right_stable_count <= 16'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cbsw_pkg::CFG_FCW_HIGH_DIST:   fcw_high_dist_cm    <= cfg_data[15:0];
          cbsw_pkg::CFG_FCW_MEDIUM_DIST: fcw_medium_dist_cm  <= cfg_data[15:0];
          cbsw_pkg::CFG_TTC_HIGH:        ttc_high_q16        <= cfg_data;
          cbsw_pkg::CFG_TTC_MEDIUM:      ttc_medium_q16      <= cfg_data;
          cbsw_pkg::CFG_BSD_RANGE:       bsd_range_cm        <= cfg_data[15:0];
          cbsw_pkg::CFG_BSD_DELTA:       side_still_cm       <= cfg_data[15:0];
          cbsw_pkg::CFG_BSD_TIMEOUT:     bsd_timeout_ticks   <= cfg_data[15:0];
          default: ;
        endcase
      end

      // drop the held result once its transfer completes, unless a new one
      // is loaded in the same cycle
      if (out_valid && out_ch.ready && state != S_LEVEL) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            front   <= in_ch.front_dist_cm;
            v       <= $signed(in_ch.closing_speed);
            a       <= $signed(in_ch.closing_accel);
            left_d  <= in_ch.left_dist_cm;
            right_d <= in_ch.right_dist_cm;
            // deadband and upper limit on own speed
            if (own < $signed({14'd0, cbsw_pkg::Q_DEADBAND})) begin
              s <= '0;
            end else if (own > $signed({14'd0, cbsw_pkg::Q_SPEED_LIMIT})) begin
              s <= cbsw_pkg::Q_SPEED_LIMIT;
            end else begin
              s <= own[17:0];
            end
            state <= S_BRK_LIN;
          end
        end
        S_BRK_LIN: state <= S_BRK_SQ;
        S_BRK_SQ: begin
          brake_lin <= prod[32:16];
          state     <= S_BRK_SUM;
        end
        S_BRK_SUM: begin
          brake <= 32'(brake_lin) + 32'(prod[34:18]) + cbsw_pkg::Q_SAFETY;
          state <= S_DIST;
        end
        S_DIST: begin
          // reciprocal product shifted down by 38
          d     <= prod[63:38];
          state <= S_SEL;
        end
        S_SEL: begin
          near_path <= near_accel;
          if (v <= cbsw_pkg::Q_MIN_CLOSING) begin
            ttc   <= cbsw_pkg::Q_TTC_INVALID;
            state <= S_LEVEL;
          end else if (near_accel) begin
            state <= S_TIME_GO;
          end else begin
            state <= S_VV;
          end
        end
        S_VV: state <= S_AD;
        S_AD: begin
          vv    <= prod[63:0];
          state <= S_WIDE;
        end
        S_WIDE: begin
          iter <= '0;
          if (wide <= 64'sd0) begin
            ttc   <= cbsw_pkg::Q_TTC_INVALID;
            state <= S_LEVEL;
          end else begin
            // floor to Q15.16 and saturate
            if (|wide[63:47]) begin
              x <= cbsw_pkg::Q_MAX[30:0];
              g <= cbsw_pkg::Q_MAX;
              state <= S_ROOT_GO;
            end else if (wide[46:16] == 31'd0) begin
              x     <= '0;
              root  <= '0;
              state <= S_TIME_GO;
            end else begin
              x <= wide[46:16];
              g <= ({1'b0, wide[46:16]} >= cbsw_pkg::Q_ONE) ? {1'b0, wide[46:16]}
                                                            : cbsw_pkg::Q_ONE;
              state <= S_ROOT_GO;
            end
          end
        end
        S_ROOT_GO: state <= S_ROOT_WAIT;
        S_ROOT_WAIT: begin
          if (div_rsp.done) begin
            // Newton step: average the guess with x / guess
            g <= gsum[32:1];
            if (iter == cbsw_pkg::ITER_W'(cbsw_pkg::SQRT_ITERATIONS - 1)) begin
              root  <= gsum[32:1];
              state <= S_TIME_GO;
            end else begin
              iter  <= iter + 1'b1;
              state <= S_ROOT_GO;
            end
          end
        end
        S_TIME_GO: state <= S_TIME_WAIT;
        S_TIME_WAIT: begin
          if (div_rsp.done) begin
            if (near_path) begin
              ttc <= (div_rsp.quotient > 49'(cbsw_pkg::Q_MAX)) ? cbsw_pkg::Q_MAX
                                                              : div_rsp.quotient[31:0];
            end else if (!t_pos || div_rsp.quotient == '0) begin
              ttc <= cbsw_pkg::Q_TTC_INVALID;
            end else begin
              ttc <= (div_rsp.quotient > 49'(cbsw_pkg::Q_MAX)) ? cbsw_pkg::Q_MAX
                                                              : div_rsp.quotient[31:0];
            end
            state <= S_LEVEL;
          end
        end
        S_LEVEL: begin
          // hold until the output register is free
          if (!out_valid || out_ch.ready) begin
            out_valid          <= 1'b1;
            out_level          <= level;
            out_left           <= left_res.warn;
            out_right          <= right_res.warn;
            left_last_dist     <= left_res.last;
            left_stable_count  <= left_res.count;
            right_last_dist    <= right_res.last;
            right_stable_count <= right_res.count;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/cbsw_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on cbsw_pkg.
module cbsw_div (
  input  logic               clk,
  input  logic               rst,
  input  cbsw_pkg::div_req_t req,
  output cbsw_pkg::div_rsp_t rsp
);

  logic [cbsw_pkg::DIVISOR_W-1:0]  rem;
  logic [cbsw_pkg::DIVIDEND_W-1:0] quo;
  logic [cbsw_pkg::DIVISOR_W-1:0]  dvs;
  logic [cbsw_pkg::DIV_CNT_W-1:0]  cnt;
  logic                            done;
  logic [cbsw_pkg::DIVISOR_W:0]    trial;
  logic [cbsw_pkg::DIVISOR_W:0]    diff;

  assign trial = {rem, quo[cbsw_pkg::DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem <= '0;
        quo <= req.dividend;
        dvs <= req.divisor;
        cnt <= cbsw_pkg::DIV_CNT_W'(cbsw_pkg::DIVIDEND_W);
      end else if (cnt != '0) begin
        // restore when the trial subtraction borrows
        if (diff[cbsw_pkg::DIVISOR_W]) begin
          rem <= trial[cbsw_pkg::DIVISOR_W-1:0];
          quo <= {quo[cbsw_pkg::DIVIDEND_W-2:0], 1'b0};
        end else begin
          rem <= diff[cbsw_pkg::DIVISOR_W-1:0];
          quo <= {quo[cbsw_pkg::DIVIDEND_W-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == cbsw_pkg::DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ hdl/cbsw_checker.sv @@
// Port-level checks on the warning block, bound to its top level.
// Depends on cbsw_pkg and collision_and_blind_spot_warning_top_defines.svh.
`include "collision_and_blind_spot_warning_top_defines.svh"

module cbsw_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_fcw_level
);

  `CBSW_ASSERT_IMP(a_level_code, clk, rst, out_valid, out_fcw_level == cbsw_pkg::FCW_NONE || out_fcw_level == cbsw_pkg::FCW_MEDIUM || out_fcw_level == cbsw_pkg::FCW_HIGH)
  `CBSW_ASSERT_NXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)
  `CBSW_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_fcw_level))

endmodule

bind collision_and_blind_spot_warning_top cbsw_checker u_cbsw_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_fcw_level (out_ch.fcw_level)
);
